>>> rtl/core/whcol_pkg.sv
package whcol_pkg;

  // The fraction is carried in Q1.16 so that it can reach one; the hue travels as h3 below.
  localparam int FRAC_BITS = 16;
  localparam int ONE_Q16 = 65536;

  localparam int HSL_BITS = 9;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_WEIGHT = 2'd0,
    REG_LIGHTNESS  = 2'd1,
    REG_SATURATION = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [FRAC_BITS:0] frac;
    logic               clipped;
  } frac_t;

  // h3 is three times the hue, in units of 1/196608 of a turn.
  typedef struct packed {
    logic [FRAC_BITS:0] h3;
    logic               clipped;
  } hue_t;

  // HSL terms in units of 1/65536: p and the ramp height q - p.
  typedef struct packed {
    logic [FRAC_BITS:0] p;
    logic [FRAC_BITS:0] diff;
  } hsl_t;

endpackage

>>> rtl/core/whcol_weight_if.sv
interface whcol_weight_if #(
  parameter int WEIGHT_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] weight;

  modport source (output valid, output weight, input ready);
  modport sink (input valid, input weight, output ready);
endinterface

>>> rtl/core/whcol_color_if.sv
interface whcol_color_if #(
  parameter int COLOR_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;
  logic                  clipped;

  modport source (output valid, output red, output green, output blue, output clipped,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input clipped,
                output ready);
endinterface

>>> rtl/core/whcol_cfg_if.sv
interface whcol_cfg_if #(
  parameter int DATA_BITS = 16
) ();
  logic                                 valid;
  logic                                 ready;
  logic [whcol_pkg::CFG_INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/weight_heatmap_hsl_color_core.sv
// Weight to heatmap color: one weight in, one RGB triple out per transfer.
// Pipeline: 24 register stages, 17 in the one-bit-per-stage divider, 3 for the hue and
// 4 for the channels. Throughput: one item per clock while the color side is ready;
// each stage advances whenever its successor frees up.
// Reset (rst, synchronous): empties the pipeline and loads max_weight 65535, lightness 128
// and saturation 205; the HSL terms derived from them settle through the ls, q and p/diff registers.
module weight_heatmap_hsl_color_core #(
  parameter int WEIGHT_BITS = 16,
  parameter int COLOR_BITS = 8
) (
  input logic                 clk,
  input logic                 rst,
  whcol_weight_if.sink        weight_ch,
  whcol_color_if.source       color_ch,
  whcol_cfg_if.sink           cfg
);

  localparam logic [WEIGHT_BITS-1:0] MAXW_RESET = WEIGHT_BITS'(32'hFFFF);
  localparam logic [whcol_pkg::HSL_BITS-1:0] LIGHT_RESET = whcol_pkg::HSL_BITS'(128);
  localparam logic [whcol_pkg::HSL_BITS-1:0] SAT_RESET = whcol_pkg::HSL_BITS'(205);
  localparam logic [whcol_pkg::FRAC_BITS:0] FRAC_ONE = 17'(whcol_pkg::ONE_Q16);
  // Largest 3 * hue: the hue at fraction zero is 0.6 of a turn.
  localparam logic [whcol_pkg::FRAC_BITS:0] HUE3_MAX = 17'(117966);

  logic [WEIGHT_BITS-1:0]          max_weight;
  logic [whcol_pkg::HSL_BITS-1:0]  lightness;
  logic [whcol_pkg::HSL_BITS-1:0]  saturation;

  logic               div_valid;
  logic               div_ready;
  whcol_pkg::frac_t   frac;
  logic               hue_valid;
  logic               hue_ready;
  whcol_pkg::hue_t    hue;
  whcol_pkg::hsl_t    hsl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_weight <= MAXW_RESET;
      lightness  <= LIGHT_RESET;
      saturation <= SAT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        whcol_pkg::REG_MAX_WEIGHT: max_weight <= cfg.data[WEIGHT_BITS-1:0];
        whcol_pkg::REG_LIGHTNESS:  lightness <= cfg.data[whcol_pkg::HSL_BITS-1:0];
        whcol_pkg::REG_SATURATION: saturation <= cfg.data[whcol_pkg::HSL_BITS-1:0];
        default: ;
      endcase
    end
  end

  whcol_div #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (weight_ch.valid),
    .in_ready   (weight_ch.ready),
    .weight     (weight_ch.weight),
    .max_weight (max_weight),
    .out_valid  (div_valid),
    .out_ready  (div_ready),
    .result     (frac)
  );

  whcol_hue u_hue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .in_ready   (div_ready),
    .frac       (frac),
    .lightness  (lightness),
    .saturation (saturation),
    .out_valid  (hue_valid),
    .out_ready  (hue_ready),
    .hue        (hue),
    .hsl        (hsl)
  );

  whcol_chan #(
    .COLOR_BITS(COLOR_BITS)
  ) u_chan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hue_valid),
    .in_ready  (hue_ready),
    .hue       (hue),
    .hsl       (hsl),
    .out_valid (color_ch.valid),
    .out_ready (color_ch.ready),
    .red       (color_ch.red),
    .green     (color_ch.green),
    .blue      (color_ch.blue),
    .clipped   (color_ch.clipped)
  );

  // The fraction never exceeds one, and a clipped item always carries exactly one.
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    div_valid |-> (frac.frac <= FRAC_ONE) && (!frac.clipped || frac.frac == FRAC_ONE))
    else $error("fraction out of range or clipped item without a saturated fraction");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hue_valid |-> (hue.h3 <= HUE3_MAX))
    else $error("hue beyond 0.6 of a turn");

  // Back-pressure at the input can only come from a full pipeline stalled at the output.
  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    !weight_ch.ready |-> (color_ch.valid && !color_ch.ready && hue_valid && div_valid))
    else $error("input stalled while the pipeline had room");

endmodule

>>> rtl/core/whcol_div.sv
module whcol_div #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [WEIGHT_BITS-1:0] max_weight,
  output logic                   out_valid,
  input  logic                   out_ready,
  output whcol_pkg::frac_t       result
);

  localparam int QB = whcol_pkg::FRAC_BITS;
  localparam int N = QB + 1;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] rem;
    logic [QB-1:0]          quo;
    logic                   zero;
    logic                   sat;
    logic                   clip;
  } div_stage_t;

  div_stage_t     st [N];
  logic [N-1:0]   vld;
  logic [N-1:0]   en;
  logic [N-1:0]   vld_in;
  logic           max_zero;
  logic           at_max;

  // A stage takes new data when it is empty or its successor moves on.
  assign en[N-1] = !vld[N-1] || out_ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign vld_in = {vld[N-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign max_zero = (max_weight == '0);
  assign at_max = (weight >= max_weight);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].rem  <= (max_zero || at_max) ? '0 : weight;
      st[0].quo  <= '0;
      st[0].zero <= max_zero;
      st[0].sat  <= at_max && !max_zero;
      st[0].clip <= (weight > max_weight) && !max_zero;
    end
  end

  // Restoring division: each stage after the first resolves one quotient bit of w * 2^16 / max.
  for (genvar k = 1; k < N; k++) begin : g_step
    logic [WEIGHT_BITS:0] r2;
    logic [WEIGHT_BITS:0] sub;
    logic                 ge;

    assign r2 = {st[k-1].rem, 1'b0};
    assign sub = r2 - {1'b0, max_weight};
    assign ge = (r2 >= {1'b0, max_weight});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k].rem  <= ge ? sub[WEIGHT_BITS-1:0] : r2[WEIGHT_BITS-1:0];
        st[k].quo  <= {st[k-1].quo[QB-2:0], ge};
        st[k].zero <= st[k-1].zero;
        st[k].sat  <= st[k-1].sat;
        st[k].clip <= st[k-1].clip;
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = vld[N-1];

  always_comb begin
    if (st[N-1].zero) begin
      result.frac = '0;
    end else if (st[N-1].sat) begin
      result.frac = (QB + 1)'(whcol_pkg::ONE_Q16);
    end else begin
      result.frac = {1'b0, st[N-1].quo};
    end
    result.clipped = st[N-1].clip;
  end

endmodule

>>> rtl/core/whcol_hue.sv
module whcol_hue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  whcol_pkg::frac_t                  frac,
  input  logic [whcol_pkg::HSL_BITS-1:0]    lightness,
  input  logic [whcol_pkg::HSL_BITS-1:0]    saturation,
  output logic                              out_valid,
  input  logic                              out_ready,
  output whcol_pkg::hue_t                   hue,
  output whcol_pkg::hsl_t                   hsl
);

  localparam int N = 3;
  localparam int QB = whcol_pkg::FRAC_BITS;
  localparam int XB = QB + 2;
  // floor(x / 5) == (x * RECIP5) >> RECIP5_SHIFT for every x below 2^18.
  localparam logic [XB-1:0] RECIP5 = XB'(209716);
  localparam int RECIP5_SHIFT = 20;
  localparam logic [whcol_pkg::HSL_BITS-1:0] HSL_ONE = whcol_pkg::HSL_BITS'(256);
  localparam logic [whcol_pkg::HSL_BITS-1:0] HSL_HALF = whcol_pkg::HSL_BITS'(128);

  logic [N-1:0]      vld;
  logic [N-1:0]      en;
  logic [N-1:0]      vld_in;
  logic [N-1:0]      clip;

  logic [QB:0]       inv;
  logic [XB-1:0]     x_next;
  logic [XB-1:0]     x_r;
  logic [2*XB-1:0]   prod;
  logic [QB-1:0]     h_r;
  logic [QB:0]       h3_r;

  logic [whcol_pkg::HSL_BITS-1:0] l_c;
  logic [whcol_pkg::HSL_BITS-1:0] s_c;
  logic [17:0]       ls_full;
  logic [QB:0]       ls_r;
  logic [9:0]        ls_sum;
  logic [18:0]       q_hi;
  logic [18:0]       q_lo;
  logic [QB:0]       q_next;
  logic [QB:0]       q_r;
  logic [17:0]       p_full;
  logic [17:0]       diff_full;
  logic [QB:0]       p_r;
  logic [QB:0]       diff_r;

  assign en[N-1] = !vld[N-1] || out_ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign vld_in = {vld[N-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Hue is 0.6 * (1 - fraction): x = 3 * (1 - F) + 2, then a divide by five.
  assign inv = (QB + 1)'(whcol_pkg::ONE_Q16) - frac.frac;
  assign x_next = {inv, 1'b0} + {1'b0, inv} + XB'(2);
  assign prod = (2 * XB)'(x_r) * (2 * XB)'(RECIP5);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r     <= x_next;
      clip[0] <= frac.clipped;
    end
    if (en[1]) begin
      h_r     <= prod[RECIP5_SHIFT +: QB];
      clip[1] <= clip[0];
    end
    if (en[2]) begin
      h3_r    <= {h_r, 1'b0} + {1'b0, h_r};
      clip[2] <= clip[1];
    end
  end

  // The HSL terms follow the registers through ls_r, q_r and p_r/diff_r, a chain far
  // shorter than the divider ahead of this block, so every item sees settled values.
  assign l_c = (lightness > HSL_ONE) ? HSL_ONE : lightness;
  assign s_c = (saturation > HSL_ONE) ? HSL_ONE : saturation;
  assign ls_full = 18'(l_c) * 18'(s_c);
  assign ls_sum = 10'(l_c) + 10'(s_c);
  assign q_hi = {1'b0, ls_sum, 8'b0} - 19'(ls_r);
  assign q_lo = 19'({l_c, 8'b0}) + 19'(ls_r);
  assign q_next = (l_c < HSL_HALF) ? q_lo[QB:0] : q_hi[QB:0];
  assign p_full = {l_c, 9'b0} - 18'(q_r);
  assign diff_full = {q_r, 1'b0} - {l_c, 9'b0};

  always_ff @(posedge clk) begin
    ls_r   <= ls_full[QB:0];
    q_r    <= q_next;
    p_r    <= p_full[QB:0];
    diff_r <= diff_full[QB:0];
  end

  assign in_ready = en[0];
  assign out_valid = vld[N-1];
  assign hue.h3 = h3_r;
  assign hue.clipped = clip[N-1];
  assign hsl.p = p_r;
  assign hsl.diff = diff_r;

endmodule

>>> rtl/core/whcol_chan.sv
module whcol_chan #(
  parameter int COLOR_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  whcol_pkg::hue_t       hue,
  input  whcol_pkg::hsl_t       hsl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_BITS-1:0] red,
  output logic [COLOR_BITS-1:0] green,
  output logic [COLOR_BITS-1:0] blue,
  output logic                  clipped
);

  localparam int N = 4;
  localparam int QB = whcol_pkg::FRAC_BITS;
  localparam int LANES = 3;
  localparam int SIXTH3 = 32768;
  localparam int HALF3 = 98304;
  localparam int TWOTHIRD3 = 131072;
  localparam int SW = 32 + COLOR_BITS;
  localparam logic [SW-1:0] ROUND = SW'(1) << 30;
  localparam logic [COLOR_BITS:0] MAXC = {1'b0, {COLOR_BITS{1'b1}}};

  logic [N-1:0]            vld;
  logic [N-1:0]            en;
  logic [N-1:0]            vld_in;
  logic [N-1:0]            clip;

  logic [QB+1:0]           h3x;
  logic [QB+1:0]           t [LANES];
  logic [QB-1:0]           d_r [LANES];
  logic [31:0]             prod_r [LANES];
  logic [31:0]             v_r [LANES];
  logic [COLOR_BITS-1:0]   c_r [LANES];

  // Position on the trapezoid: rising edge, flat top, falling edge, floor.
  // The channel is p + (q - p) * d / one-sixth, so the flat top is d = one-sixth.
  function automatic logic [QB-1:0] ramp_pos(input logic [QB+1:0] pos);
    logic [QB+1:0] back;
    back = (QB + 2)'(TWOTHIRD3) - pos;
    if (pos < (QB + 2)'(SIXTH3)) begin
      ramp_pos = pos[QB-1:0];
    end else if (pos < (QB + 2)'(HALF3)) begin
      ramp_pos = QB'(SIXTH3);
    end else if (pos < (QB + 2)'(TWOTHIRD3)) begin
      ramp_pos = back[QB-1:0];
    end else begin
      ramp_pos = '0;
    end
  endfunction

  assign en[N-1] = !vld[N-1] || out_ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign vld_in = {vld[N-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      clip[0] <= hue.clipped;
    end
    for (int k = 1; k < N; k++) begin
      if (en[k]) begin
        clip[k] <= clip[k-1];
      end
    end
  end

  // Red sits a third of a turn ahead of green, blue a third behind (wrapped).
  assign h3x = {1'b0, hue.h3};
  assign t[0] = h3x + (QB + 2)'(whcol_pkg::ONE_Q16);
  assign t[1] = h3x;
  assign t[2] = (h3x >= (QB + 2)'(whcol_pkg::ONE_Q16)) ?
                h3x - (QB + 2)'(whcol_pkg::ONE_Q16) : h3x + (QB + 2)'(TWOTHIRD3);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [32:0]   mul;
    logic [SW-1:0] sc;
    logic [COLOR_BITS:0] ctop;

    assign mul = 33'(hsl.diff) * 33'(d_r[i]);
    // v * maxc is v * 2^COLOR_BITS - v.
    assign sc = {v_r[i], {COLOR_BITS{1'b0}}} - SW'(v_r[i]) + ROUND;
    assign ctop = sc[SW-1:31];

    always_ff @(posedge clk) begin
      if (en[0]) begin
        d_r[i] <= ramp_pos(t[i]);
      end
      if (en[1]) begin
        prod_r[i] <= mul[31:0];
      end
      if (en[2]) begin
        v_r[i] <= prod_r[i] + {hsl.p[15:0], 15'b0} + {hsl.p[QB], 31'b0};
      end
      if (en[3]) begin
        c_r[i] <= (ctop > MAXC) ? MAXC[COLOR_BITS-1:0] : ctop[COLOR_BITS-1:0];
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = vld[N-1];
  assign red = c_r[0];
  assign green = c_r[1];
  assign blue = c_r[2];
  assign clipped = clip[N-1];

endmodule

>>> sim/whcol_color_checker.sv
`timescale 1ns / 1ps

module whcol_color_checker #(
  parameter int WEIGHT_BITS = 16,
  parameter int COLOR_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  whcol_weight_if weight_ch,
  whcol_color_if  color_ch,
  whcol_cfg_if    cfg,
  output int      errors,
  output int      pending
);
  import whcol_pkg::*;

  // Hue positions in units of 1/196608 of a turn.
  localparam longint TURN = 196608;
  localparam longint SIXTH = 32768;
  localparam longint HALF = 98304;
  localparam longint TWO_THIRDS = 131072;
  localparam longint COLOR_MAX = (longint'(1) << COLOR_BITS) - 1;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  clipped;
  } color_t;

  typedef struct {
    logic [WEIGHT_BITS-1:0] weight;
    color_t                 color;
  } color_entry_t;

  logic [WEIGHT_BITS-1:0] max_weight;
  logic [HSL_BITS-1:0]    lightness;
  logic [HSL_BITS-1:0]    saturation;
  color_entry_t           color_q [$];

  // Channel level in units of 1/2^31 for hue position t.
  function automatic longint ramp_level(input longint p, input longint q, input longint t);
    longint pos;
    pos = t;
    if (pos < 0) pos += TURN;
    if (pos > TURN) pos -= TURN;
    if (pos < SIXTH) return p * SIXTH + (q - p) * pos;
    if (pos < HALF) return q * SIXTH;
    if (pos < TWO_THIRDS) return p * SIXTH + (q - p) * (TWO_THIRDS - pos);
    return p * SIXTH;
  endfunction

  function automatic logic [COLOR_BITS-1:0] quantize(input longint v);
    longint c;
    if (v <= 0) return '0;
    c = (v * COLOR_MAX + (longint'(1) << 30)) >>> 31;
    if (c > COLOR_MAX) c = COLOR_MAX;
    return c[COLOR_BITS-1:0];
  endfunction

  function automatic color_t predict_color(input logic [WEIGHT_BITS-1:0] w);
    longint wl, ml, frac, hue, l, s, q, p, h3;
    color_t c;
    wl = w;
    ml = max_weight;
    c.clipped = 1'b0;
    if (ml == 0) begin
      frac = 0;
    end else if (wl >= ml) begin
      frac = ONE_Q16;
      c.clipped = (wl > ml);
    end else begin
      frac = (wl << FRAC_BITS) / ml;
    end
    hue = ((ONE_Q16 - frac) * 3 + 2) / 5;
    l = lightness;
    s = saturation;
    if (l > 256) l = 256;
    if (s > 256) s = 256;
    if (l < 128) q = l * (256 + s);
    else q = (l + s) * 256 - l * s;
    p = 2 * l * 256 - q;
    h3 = 3 * hue;
    c.red = quantize(ramp_level(p, q, h3 + ONE_Q16));
    c.green = quantize(ramp_level(p, q, h3));
    c.blue = quantize(ramp_level(p, q, h3 - ONE_Q16));
    return c;
  endfunction

  always @(posedge clk) begin
    color_t       got;
    color_entry_t want;
    if (rst) begin
      max_weight = '1;
      lightness = 9'd128;
      saturation = 9'd205;
      color_q.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MAX_WEIGHT: max_weight = cfg.data[WEIGHT_BITS-1:0];
          REG_LIGHTNESS:  lightness = cfg.data[HSL_BITS-1:0];
          REG_SATURATION: saturation = cfg.data[HSL_BITS-1:0];
          default: ;
        endcase
      end
      if (color_ch.valid && color_ch.ready) begin
        got.red = color_ch.red;
        got.green = color_ch.green;
        got.blue = color_ch.blue;
        got.clipped = color_ch.clipped;
        if (color_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected color r=%0d g=%0d b=%0d clipped=%0d", $realtime,
                     got.red, got.green, got.blue, got.clipped);
        end else begin
          want = color_q.pop_front();
          if (got.red !== want.color.red || got.green !== want.color.green ||
              got.blue !== want.color.blue || got.clipped !== want.color.clipped) begin
            errors++;
            if (errors <= 10)
              $display("%0t: weight %0d expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       $realtime, want.weight, want.color.red, want.color.green,
                       want.color.blue, want.color.clipped, got.red, got.green, got.blue,
                       got.clipped);
          end
        end
      end
      if (weight_ch.valid && weight_ch.ready) begin
        want.weight = weight_ch.weight;
        want.color = predict_color(weight_ch.weight);
        color_q.insert(color_q.size(), want);
      end
    end
    pending = color_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import whcol_pkg::*;

  localparam int WEIGHT_BITS = 16;
  localparam int COLOR_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 4000;
  // The HSL terms follow a register write through ls_r, q_r and p_r/diff_r.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 40;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending_colors;
  int   burst_left;
  int   hold_reqs;
  int   idle_cycles;

  whcol_weight_if #(.WEIGHT_BITS(WEIGHT_BITS)) w_ch ();
  whcol_color_if #(.COLOR_BITS(COLOR_BITS)) c_ch ();
  whcol_cfg_if cfg_ch ();

  weight_heatmap_hsl_color_core #(
    .WEIGHT_BITS(WEIGHT_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .weight_ch(w_ch),
    .color_ch(c_ch),
    .cfg(cfg_ch)
  );

  whcol_color_checker #(
    .WEIGHT_BITS(WEIGHT_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) u_color_check (
    .clk(clk),
    .rst(rst),
    .weight_ch(w_ch),
    .color_ch(c_ch),
    .cfg(cfg_ch),
    .errors(mismatches),
    .pending(pending_colors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one weight, then either keeps the burst going or starts a new one, mostly after a gap.
  task automatic offer_weight(input logic [WEIGHT_BITS-1:0] w);
    int gap;
    w_ch.valid <= 1'b1;
    w_ch.weight <= w;
    @(posedge clk);
    while (!w_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 30);
      if (gap > 0) begin
        w_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Waits until the pipeline is empty, then writes the registers back to back.
  task automatic set_colormap(input logic [15:0] mw, input logic [15:0] light,
                              input logic [15:0] sat, input bit junk);
    logic [CFG_INDEX_BITS-1:0] idx [4];
    logic [15:0]               val [4];
    w_ch.valid <= 1'b0;
    while (pending_colors != 0) @(negedge clk);
    idx[0] = REG_UNUSED;
    idx[1] = REG_MAX_WEIGHT;
    idx[2] = REG_LIGHTNESS;
    idx[3] = REG_SATURATION;
    val[0] = 16'($urandom);
    val[1] = mw;
    val[2] = light;
    val[3] = sat;
    for (int i = junk ? 0 : 1; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data <= val[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : color_sink
    rx_mode_t mode;
    int mode_left, hold_seen, hold_left;
    mode = RX_OPEN;
    mode_left = 0;
    hold_seen = 0;
    hold_left = 0;
    c_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        c_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   c_ch.ready <= 1'b1;
          RX_RANDOM: c_ch.ready <= 1'($urandom_range(0, 1));
          default:   c_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Ends the run when nothing has transferred for too long.
  always @(posedge clk) begin
    if (rst || (w_ch.valid && w_ch.ready) || (c_ch.valid && c_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : weight_source
    logic [WEIGHT_BITS-1:0] dir_w [$];
    logic [15:0]            mw, lt, st;
    logic [WEIGHT_BITS-1:0] w;
    rst = 1'b1;
    w_ch.valid = 1'b0;
    w_ch.weight = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAX_WEIGHT;
    cfg_ch.data = '0;
    burst_left = 0;
    hold_reqs = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    // Reset settings: range ends, midpoint and alternating bit patterns.
    dir_w = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'h8000, 16'h5555, 16'hAAAA,
              16'd13107, 16'd52428};
    foreach (dir_w[i]) offer_weight(dir_w[i]);

    // Weight just below, equal to and above the maximum; full lightness and saturation.
    set_colormap(16'd1000, 16'd256, 16'd256, 1'b1);
    dir_w = '{16'd999, 16'd1000, 16'd1001, 16'd0, 16'd500};
    foreach (dir_w[i]) offer_weight(dir_w[i]);

    // Zero maximum, zero lightness and saturation.
    set_colormap(16'd0, 16'd0, 16'd0, 1'b0);
    dir_w = '{16'd0, 16'hFFFF, 16'd12345};
    foreach (dir_w[i]) offer_weight(dir_w[i]);

    // Lightness and saturation above 1.0 saturate, upper data bits are dropped.
    set_colormap(16'hFFFF, 16'd511, 16'hFFFF, 1'b0);
    dir_w = '{16'd0, 16'hFFFF, 16'd32767, 16'd21845};
    foreach (dir_w[i]) offer_weight(dir_w[i]);

    set_colormap(16'd1, 16'hFE7F, 16'h0100, 1'b1);
    dir_w = '{16'd0, 16'd1, 16'd2};
    foreach (dir_w[i]) offer_weight(dir_w[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: mw = 16'($urandom);
        1: mw = 16'($urandom_range(1, 300));
        2: mw = 16'd0;
        default: mw = 16'hFFFF;
      endcase
      case ($urandom_range(0, 4))
        0: lt = 16'($urandom);
        1: lt = 16'd0;
        2: lt = 16'd256;
        default: lt = 16'($urandom_range(0, 256));
      endcase
      case ($urandom_range(0, 4))
        0: st = 16'($urandom);
        1: st = 16'd0;
        2: st = 16'd256;
        default: st = 16'($urandom_range(0, 256));
      endcase
      if (ph == 0) begin
        mw = 16'hFFFF;
        lt = 16'd128;
        st = 16'd205;
      end else if (ph == 1) begin
        mw = 16'hFFFF;
        lt = 16'd0;
        st = 16'd0;
      end else if (ph == 2) begin
        mw = 16'($urandom_range(1, 64));
        lt = 16'd256;
        st = 16'd256;
      end
      set_colormap(mw, lt, st, (ph % 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: w = 16'($urandom);
          5, 6: w = mw + 16'($urandom_range(0, 6)) - 16'd3;
          7: w = 16'($urandom_range(0, mw));
          8: w = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
          default: w = 16'($urandom_range(0, 15));
        endcase
        // Stall the color side for a long stretch while weights keep coming,
        // so the pipeline fills and backs up into the weight channel.
        if (ph == 4 && n == 40) begin
          hold_reqs <= hold_reqs + 1;
          burst_left = 300;
        end
        offer_weight(w);
      end
    end

    w_ch.valid <= 1'b0;
    while (pending_colors != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_colors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
